/* rtl/wvenv_pkg.sv */
// Shared types and constants of the wavetable voice.
`default_nettype none
package wvenv_pkg;

    localparam int TABLE_DEPTH_DEF   = 4096;
    localparam int GUARD_SAMPLES_DEF = 60;

    localparam int COMP_THRESH = 29491;
    localparam int COMP_LIMIT  = 32440;

    localparam int CFG_DW = 20;

    typedef enum logic [2:0] {
        OP_TICK     = 3'd0,
        OP_NOTE_ON  = 3'd1,
        OP_REST     = 3'd2,
        OP_SILENT   = 3'd3,
        OP_TABLE_WR = 3'd4,
        OP_RESTART  = 3'd5
    } op_t;

    typedef enum logic [2:0] {
        CFG_ATTACK  = 3'd0,
        CFG_HOLD    = 3'd1,
        CFG_DECAY   = 3'd2,
        CFG_RELEASE = 3'd3,
        CFG_PEAK    = 3'd4,
        CFG_SUSTAIN = 3'd5,
        CFG_GAIN    = 3'd6,
        CFG_DRIVE   = 3'd7
    } cfg_idx_t;

    typedef enum logic [9:0] {
        S_IDLE    = 10'b00_0000_0001,
        S_ENV     = 10'b00_0000_0010,
        S_DIV_ENV = 10'b00_0000_0100,
        S_MUL_ENV = 10'b00_0000_1000,
        S_DRV     = 10'b00_0001_0000,
        S_CMP     = 10'b00_0010_0000,
        S_GAIN    = 10'b00_0100_0000,
        S_YCALC   = 10'b00_1000_0000,
        S_DIV_GRD = 10'b01_0000_0000,
        S_OUT     = 10'b10_0000_0000
    } state_t;

endpackage
`default_nettype wire

/* rtl/wavetable_voice_with_envelope_top.sv */
// Top level of the wavetable voice: sequencer, envelope, datapath and wave table.
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+------------------------------------------
//  in      | input     | in_valid/in_ready  | opcode, note_increment, table_index/value
//  out     | output    | out_valid/out_ready| sample, envelope_level
//  cfg     | input     | cfg_we             | cfg_index, cfg_data
//
// A non-tick opcode is done once taken. A tick steps through the states: the restoring
// divider runs 15 steps plus a finishing step for an envelope ratio, drive adds S_CMP and
// the pop guard blend adds S_DIV_GRD (reciprocal multiply by the constant guard length).
// The wave table has one read per tick.
// Reset initializes all control state; the table (power-of-two depth) is loaded by the user.
// A finished sample waits in the output register; a new item is taken meanwhile,
// but a following tick holds in its last state until the register is free.
`default_nettype none
module wavetable_voice_with_envelope_top #(
    parameter int TABLE_DEPTH   = wvenv_pkg::TABLE_DEPTH_DEF,
    parameter int GUARD_SAMPLES = wvenv_pkg::GUARD_SAMPLES_DEF
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire logic [2:0]         opcode,
    input  wire logic [30:0]        note_increment,
    input  wire logic [11:0]        table_index,
    input  wire logic signed [15:0] table_value,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output logic signed [15:0]      sample,
    output logic [14:0]             envelope_level,
    input  wire logic               cfg_we,
    input  wire logic [2:0]         cfg_index,
    input  wire logic [wvenv_pkg::CFG_DW-1:0] cfg_data
);

    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int PW = AW + 20;
    localparam int SW = ((PW > 31) ? PW : 31) + 1;

    // floor(x / GUARD_SAMPLES) == (x * GRD_RECIP) >> 29 for any x below 2^23
    localparam logic [29:0] GRD_RECIP =
        30'(((64'd1 << 29) + 64'(GUARD_SAMPLES) - 64'd1) / 64'(GUARD_SAMPLES));

    // configuration
    logic [19:0]        attack_reg, hold_reg, decay_reg, release_reg;
    logic [14:0]        peak_reg, sustain_reg;
    logic signed [15:0] gain_reg;
    logic [15:0]        drive_reg;

    // voice state
    logic [PW-1:0]      phase_reg;
    logic [30:0]        step_reg;
    logic [21:0]        pos_reg;
    logic [20:0]        rpos_reg;
    logic               main_done_reg, rel_done_reg, resting_reg, silence_reg;
    logic [5:0]         guard_reg;
    logic signed [15:0] last_reg;

    wvenv_pkg::state_t  state_reg, state_next;

    // datapath
    logic [14:0]        env_reg;
    logic               is_decay_reg, dec_up_reg, clear_phase_reg;
    logic signed [15:0] v1_reg, v2_reg, y_reg;
    logic signed [32:0] dprod_reg;
    logic signed [31:0] gprod_reg;
    logic               dneg_reg;
    logic               out_valid_reg;
    logic signed [15:0] sample_reg;
    logic [14:0]        envout_reg;

    // envelope divider; div_sh_reg also holds the guard blend numerator
    logic [20:0]        div_rem_reg;
    logic [22:0]        div_sh_reg;
    logic [4:0]         div_cnt_reg;
    logic [19:0]        div_den_reg;

    logic [AW-1:0]      ram_waddr;
    logic               ram_we;
    logic [15:0]        ram_wdata;
    logic signed [15:0] ram_rdata;
    logic               ram_re;

    logic               in_xfer;
    wvenv_pkg::op_t     op;
    logic [31:0]        idx_ext;

    assign in_ready = (state_reg == wvenv_pkg::S_IDLE);
    assign in_xfer  = in_valid && in_ready;
    assign op       = wvenv_pkg::op_t'(opcode);
    assign idx_ext  = 32'(table_index);
    assign out_valid      = out_valid_reg;
    assign sample         = sample_reg;
    assign envelope_level = envout_reg;

    // table write with saturation
    always_comb
    begin
        ram_we    = in_xfer && (op == wvenv_pkg::OP_TABLE_WR) &&
                    (idx_ext < 32'(TABLE_DEPTH));
        ram_waddr = idx_ext[AW-1:0];
        if (table_value > 16'sd32440)
            ram_wdata = 16'(wvenv_pkg::COMP_LIMIT);
        else if (table_value < -16'sd32440)
            ram_wdata = 16'(-wvenv_pkg::COMP_LIMIT);
        else
            ram_wdata = table_value;
    end

    assign ram_re = (state_reg == wvenv_pkg::S_ENV);

    wvenv_ram #(
        .WIDTH (16),
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .clk     (clk),
        .wr_en   (ram_we),
        .wr_addr (ram_waddr),
        .wr_data (ram_wdata),
        .rd_en   (ram_re),
        .rd_addr (phase_reg[PW-1:20]),
        .rd_data (ram_rdata)
    );

    // envelope stage selection
    logic [20:0] hold_end;
    logic [21:0] all_end;
    logic [21:0] span;
    logic signed [15:0] pk_diff;
    logic [14:0] mul_a;
    logic [19:0] mul_b, env_den;
    logic [34:0] env_prod;
    logic        env_div, env_silent;
    logic [14:0] env_direct;
    logic        env_dec, env_up;

    always_comb
    begin
        hold_end   = {1'b0, attack_reg} + {1'b0, hold_reg};
        all_end    = {1'b0, hold_end} + {2'b0, decay_reg};
        span       = pos_reg - {1'b0, hold_end};
        pk_diff    = $signed({1'b0, peak_reg}) - $signed({1'b0, sustain_reg});
        mul_a      = '0;
        mul_b      = '0;
        env_den    = '0;
        env_div    = 1'b0;
        env_silent = 1'b0;
        env_direct = '0;
        env_dec    = 1'b0;
        env_up     = pk_diff[15];
        priority if (resting_reg)
        begin
            if (!rel_done_reg && !silence_reg)
            begin
                if (rpos_reg < {1'b0, release_reg})
                begin
                    mul_a   = sustain_reg;
                    mul_b   = 20'(release_reg - rpos_reg[19:0]);
                    env_den = release_reg;
                    env_div = 1'b1;
                end
            end
            else
            begin
                env_silent = 1'b1;
            end
        end
        else if (pos_reg < {2'b0, attack_reg})
        begin
            mul_a   = peak_reg;
            mul_b   = pos_reg[19:0];
            env_den = attack_reg;
            env_div = 1'b1;
        end
        else if (pos_reg < {1'b0, hold_end})
        begin
            env_direct = peak_reg;
        end
        else if (pos_reg < all_end)
        begin
            mul_a   = pk_diff[15] ? 15'(-pk_diff) : pk_diff[14:0];
            mul_b   = span[19:0];
            env_den = decay_reg;
            env_div = 1'b1;
            env_dec = 1'b1;
        end
        else
        begin
            env_direct = sustain_reg;
        end
        env_prod = 35'(mul_a) * 35'(mul_b);
    end

    // divider step
    logic [21:0] div_t;
    logic        div_ge;
    logic [20:0] div_rem_n;
    logic [22:0] div_sh_n;

    always_comb
    begin
        div_t     = {div_rem_reg, div_sh_reg[22]};
        div_ge    = div_t >= {2'b0, div_den_reg};
        div_rem_n = div_ge ? 21'(div_t - {2'b0, div_den_reg}) : div_t[20:0];
        div_sh_n  = {div_sh_reg[21:0], div_ge};
    end

    // arithmetic
    logic signed [31:0] p1, p1b;
    logic signed [32:0] p2, p2b;
    logic signed [20:0] vd;
    logic signed [21:0] ct, cr;
    logic signed [15:0] comp_v;
    logic signed [31:0] pg, pgb;
    logic signed [15:0] y_c;
    logic signed [16:0] gdiff;
    logic [16:0]        gmag;
    logic [22:0]        gprod_g;
    logic [52:0]        grd_prod;
    logic [22:0]        grd_q;
    logic [14:0]        env_fin;
    logic signed [23:0] y_sum;
    logic [SW-1:0]      phase_sum;

    always_comb
    begin
        p1  = 32'($signed(ram_rdata)) * 32'($signed({1'b0, env_reg}));
        p1b = p1 + (p1[31] ? 32'sd32767 : 32'sd0);

        p2  = 33'($signed(v1_reg)) * 33'($signed({1'b0, drive_reg}));
        p2b = dprod_reg + (dprod_reg[32] ? 33'sd4095 : 33'sd0);
        vd  = p2b[32:12];
        ct  = '0;
        cr  = 22'(vd);
        if (vd > 21'sd29491)
        begin
            ct = 22'(vd) - 22'sd29491;
            cr = 22'sd29491 + (ct >>> 2);
            if (cr >= 22'sd32440)
                cr = 22'sd32440;
        end
        else if (vd < -21'sd29491)
        begin
            ct = 22'(vd) + 22'sd29491;
            cr = -22'sd29491 + ((ct + 22'sd3) >>> 2);
            if (cr <= -22'sd32440)
                cr = -22'sd32440;
        end
        comp_v = cr[15:0];

        pg  = 32'(v2_reg) * 32'(gain_reg);
        pgb = gprod_reg + (gprod_reg[31] ? 32'sd32767 : 32'sd0);
        y_c = pgb[30:15];

        gdiff   = 17'(last_reg) - 17'(y_c);
        gmag    = gdiff[16] ? 17'(-gdiff) : gdiff;
        gprod_g = 23'(gmag) * 23'(guard_reg);

        grd_prod = 53'(div_sh_reg) * 53'(GRD_RECIP);
        grd_q    = grd_prod[51:29];

        if (is_decay_reg)
            env_fin = dec_up_reg ? 15'(peak_reg + div_sh_reg[14:0])
                                 : 15'(peak_reg - div_sh_reg[14:0]);
        else
            env_fin = div_sh_reg[14:0];

        y_sum = dneg_reg ? 24'(y_reg) - 24'(grd_q) : 24'(y_reg) + 24'(grd_q);

        phase_sum = (clear_phase_reg ? SW'(0) : SW'(phase_reg)) + SW'(step_reg);
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            wvenv_pkg::S_IDLE:
                if (in_xfer && op == wvenv_pkg::OP_TICK)
                    state_next = wvenv_pkg::S_ENV;
            wvenv_pkg::S_ENV:
                state_next = env_div ? wvenv_pkg::S_DIV_ENV : wvenv_pkg::S_MUL_ENV;
            wvenv_pkg::S_DIV_ENV:
                if (div_cnt_reg == '0)
                    state_next = wvenv_pkg::S_MUL_ENV;
            wvenv_pkg::S_MUL_ENV:
                state_next = wvenv_pkg::S_DRV;
            wvenv_pkg::S_DRV:
                state_next = (drive_reg == '0) ? wvenv_pkg::S_GAIN : wvenv_pkg::S_CMP;
            wvenv_pkg::S_CMP:
                state_next = wvenv_pkg::S_GAIN;
            wvenv_pkg::S_GAIN:
                state_next = wvenv_pkg::S_YCALC;
            wvenv_pkg::S_YCALC:
                state_next = (guard_reg != '0) ? wvenv_pkg::S_DIV_GRD : wvenv_pkg::S_OUT;
            wvenv_pkg::S_DIV_GRD:
                state_next = wvenv_pkg::S_OUT;
            wvenv_pkg::S_OUT:
                if (!out_valid_reg || out_ready)
                    state_next = wvenv_pkg::S_IDLE;
            default:
                state_next = wvenv_pkg::S_IDLE;
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= wvenv_pkg::S_IDLE;
            attack_reg    <= 20'd1000;
            hold_reg      <= 20'd1000;
            decay_reg     <= 20'd9600;
            release_reg   <= 20'd2000;
            peak_reg      <= 15'd29491;
            sustain_reg   <= 15'd16384;
            gain_reg      <= 16'sd16384;
            drive_reg     <= '0;
            phase_reg     <= '0;
            step_reg      <= '0;
            pos_reg       <= '0;
            rpos_reg      <= '0;
            main_done_reg <= 1'b0;
            rel_done_reg  <= 1'b1;
            resting_reg   <= 1'b0;
            silence_reg   <= 1'b0;
            guard_reg     <= '0;
            last_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;

            if (cfg_we)
            begin
                unique case (wvenv_pkg::cfg_idx_t'(cfg_index))
                    wvenv_pkg::CFG_ATTACK:  attack_reg  <= cfg_data[19:0];
                    wvenv_pkg::CFG_HOLD:    hold_reg    <= cfg_data[19:0];
                    wvenv_pkg::CFG_DECAY:   decay_reg   <= cfg_data[19:0];
                    wvenv_pkg::CFG_RELEASE: release_reg <= cfg_data[19:0];
                    wvenv_pkg::CFG_PEAK:    peak_reg    <= cfg_data[14:0];
                    wvenv_pkg::CFG_SUSTAIN: sustain_reg <= cfg_data[14:0];
                    wvenv_pkg::CFG_GAIN:    gain_reg    <= $signed(cfg_data[15:0]);
                    wvenv_pkg::CFG_DRIVE:   drive_reg   <= cfg_data[15:0];
                    default: ;
                endcase
            end

            if (in_xfer)
            begin
                unique case (op)
                    wvenv_pkg::OP_NOTE_ON:
                    begin
                        silence_reg   <= 1'b0;
                        step_reg      <= note_increment;
                        pos_reg       <= '0;
                        main_done_reg <= 1'b0;
                        rpos_reg      <= '0;
                        rel_done_reg  <= 1'b0;
                        resting_reg   <= 1'b0;
                        guard_reg     <= 6'(GUARD_SAMPLES);
                    end
                    wvenv_pkg::OP_REST:   resting_reg <= 1'b1;
                    wvenv_pkg::OP_SILENT: silence_reg <= 1'b1;
                    wvenv_pkg::OP_RESTART:
                    begin
                        phase_reg     <= '0;
                        last_reg      <= '0;
                        pos_reg       <= '0;
                        main_done_reg <= 1'b0;
                        rpos_reg      <= '0;
                        rel_done_reg  <= 1'b0;
                    end
                    default: ;
                endcase
            end

            if (state_reg == wvenv_pkg::S_YCALC && guard_reg == '0)
                last_reg <= y_c;
            if (state_reg == wvenv_pkg::S_DIV_GRD)
                guard_reg <= guard_reg - 6'd1;

            if (state_reg == wvenv_pkg::S_OUT && (!out_valid_reg || out_ready))
                out_valid_reg <= 1'b1;
            else if (out_valid_reg && out_ready)
                out_valid_reg <= 1'b0;

            if (state_reg == wvenv_pkg::S_OUT && (!out_valid_reg || out_ready))
            begin
                phase_reg <= phase_sum[PW-1:0];
                if (!resting_reg)
                begin
                    if (!main_done_reg)
                    begin
                        pos_reg <= pos_reg + 22'd1;
                        if ({1'b0, pos_reg} + 23'd1 >= {1'b0, all_end})
                            main_done_reg <= 1'b1;
                    end
                end
                else if (!rel_done_reg)
                begin
                    rpos_reg <= rpos_reg + 21'd1;
                    if ({1'b0, rpos_reg} + 22'd1 >= {2'b0, release_reg})
                        rel_done_reg <= 1'b1;
                end
            end
        end
    end

    // datapath and divider
    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            wvenv_pkg::S_ENV:
            begin
                clear_phase_reg <= env_silent;
                is_decay_reg    <= env_dec;
                dec_up_reg      <= env_up;
                env_reg         <= env_direct;
                div_rem_reg     <= {1'b0, env_prod[34:15]};
                div_sh_reg      <= {env_prod[14:0], 8'b0};
                div_cnt_reg     <= 5'd15;
                div_den_reg     <= env_den;
            end
            wvenv_pkg::S_DIV_ENV:
            begin
                if (div_cnt_reg != '0)
                begin
                    div_rem_reg <= div_rem_n;
                    div_sh_reg  <= div_sh_n;
                    div_cnt_reg <= div_cnt_reg - 5'd1;
                end
                else
                    env_reg <= env_fin;
            end
            wvenv_pkg::S_DIV_GRD:
                y_reg <= y_sum[15:0];
            wvenv_pkg::S_MUL_ENV:
                v1_reg <= p1b[30:15];
            wvenv_pkg::S_DRV:
            begin
                dprod_reg <= p2;
                v2_reg    <= v1_reg;
            end
            wvenv_pkg::S_CMP:
                v2_reg <= comp_v;
            wvenv_pkg::S_GAIN:
                gprod_reg <= pg;
            wvenv_pkg::S_YCALC:
            begin
                y_reg      <= y_c;
                dneg_reg   <= gdiff[16];
                div_sh_reg <= gprod_g;
            end
            wvenv_pkg::S_OUT:
                if (!out_valid_reg || out_ready)
                begin
                    sample_reg <= y_reg;
                    envout_reg <= env_reg;
                end
            default: ;
        endcase
    end

    // divider never runs on a zero divisor
    a_div_den: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == wvenv_pkg::S_DIV_ENV) |-> div_den_reg != '0)
        else $error("divider started with zero divisor");

    a_tick_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (in_xfer && op == wvenv_pkg::OP_TICK) |=> !in_ready)
        else $error("tick transfer did not start processing");

    a_guard_max: assert property (@(posedge clk) disable iff (!rst_n)
        guard_reg <= 6'(GUARD_SAMPLES))
        else $error("guard count above its start value");

endmodule
`default_nettype wire

/* rtl/wvenv_ram.sv */
// Generic single-clock RAM, one write port, one registered read port.
`default_nettype none
module wvenv_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 4096
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule
`default_nettype wire

/* bench/tb_wavetable_voice_with_envelope_top.sv */
// Self-checking testbench for the wavetable voice with envelope.
`timescale 1ns / 1ps

module tb_wavetable_voice_with_envelope_top;

    localparam int DEPTH      = wvenv_pkg::TABLE_DEPTH_DEF;
    localparam int GUARD_LEN  = wvenv_pkg::GUARD_SAMPLES_DEF;
    localparam int ONE_Q15    = 32768;
    localparam int DRAIN_WAIT = 64;
    localparam int LIMIT      = 600000;
    // entries loaded up front; note steps stay at or below half an entry per tick,
    // so the few hundred random ticks never reach past them
    localparam int FILL_LEN   = 128;

    // Voice predictor: holds its own copy of the registers, the table and the voice state.
    class voice_scoreboard;
        int unsigned att_len, hld_len, dec_len, rel_len, peak, sus, drive;
        int          gain;
        logic signed [15:0] wave [DEPTH];
        longint unsigned phase;
        int unsigned step, env_pos, rel_pos, guard;
        bit          main_done, rel_done, resting, silent;
        int          last_out;
        logic signed [15:0] exp_sample [$];
        logic [14:0]        exp_level [$];
        int          errors, shown;

        function void clear();
            att_len = 1000; hld_len = 1000; dec_len = 9600; rel_len = 2000;
            peak = 29491; sus = 16384; gain = 16384; drive = 0;
            phase = 0; step = 0; env_pos = 0; rel_pos = 0;
            main_done = 0; rel_done = 1; resting = 0; silent = 0;
            guard = 0; last_out = 0; errors = 0; shown = 0;
            foreach (wave[i]) wave[i] = '0;
        endfunction

        function void set_reg(wvenv_pkg::cfg_idx_t idx, logic [19:0] d);
            case (idx)
                wvenv_pkg::CFG_ATTACK:  att_len = d;
                wvenv_pkg::CFG_HOLD:    hld_len = d;
                wvenv_pkg::CFG_DECAY:   dec_len = d;
                wvenv_pkg::CFG_RELEASE: rel_len = d;
                wvenv_pkg::CFG_PEAK:    peak = d[14:0];
                wvenv_pkg::CFG_SUSTAIN: sus = d[14:0];
                wvenv_pkg::CFG_GAIN:    gain = $signed(d[15:0]);
                wvenv_pkg::CFG_DRIVE:   drive = d[15:0];
                default: ;
            endcase
        endfunction

        function void restart_env();
            env_pos = 0; main_done = 0; rel_pos = 0; rel_done = 0;
        endfunction

        function int unsigned level_now();
            longint unsigned hold_end, all_end, span, mag;
            int diff;
            if (resting) begin
                if (!rel_done && !silent) begin
                    if (rel_pos >= rel_len) return 0;
                    return 32'((longint'(sus) * (rel_len - rel_pos)) / rel_len);
                end
                phase = 0;
                return 0;
            end
            hold_end = longint'(att_len) + hld_len;
            all_end  = hold_end + dec_len;
            if (env_pos < att_len) return 32'((longint'(peak) * env_pos) / att_len);
            if (env_pos < hold_end) return peak;
            if (env_pos < all_end) begin
                diff = int'(peak) - int'(sus);
                span = env_pos - hold_end;
                mag  = longint'(diff < 0 ? -diff : diff) * span / dec_len;
                return 32'((diff >= 0) ? peak - mag : peak + mag);
            end
            return sus;
        endfunction

        function longint soft_clip(longint v);
            longint r;
            r = v;
            if (v > wvenv_pkg::COMP_THRESH) begin
                r = wvenv_pkg::COMP_THRESH + (v - wvenv_pkg::COMP_THRESH) / 4;
                if (r >= wvenv_pkg::COMP_LIMIT) r = wvenv_pkg::COMP_LIMIT;
            end else if (v < -wvenv_pkg::COMP_THRESH) begin
                r = -wvenv_pkg::COMP_THRESH + (v + wvenv_pkg::COMP_THRESH) / 4;
                if (r <= -wvenv_pkg::COMP_LIMIT) r = -wvenv_pkg::COMP_LIMIT;
            end
            return r;
        endfunction

        function void note_input(logic [2:0] op, logic [30:0] inc, logic [11:0] idx,
                                 logic signed [15:0] val);
            int unsigned ph, lvl;
            longint v, d;
            int y, w;
            case (op)
                wvenv_pkg::OP_NOTE_ON: begin
                    silent = 0; step = inc; restart_env(); resting = 0; guard = GUARD_LEN;
                end
                wvenv_pkg::OP_REST:   resting = 1;
                wvenv_pkg::OP_SILENT: silent = 1;
                wvenv_pkg::OP_TABLE_WR: begin
                    w = val;
                    if (w > wvenv_pkg::COMP_LIMIT) w = wvenv_pkg::COMP_LIMIT;
                    if (w < -wvenv_pkg::COMP_LIMIT) w = -wvenv_pkg::COMP_LIMIT;
                    wave[idx] = w[15:0];
                end
                wvenv_pkg::OP_RESTART: begin
                    phase = 0; last_out = 0; restart_env();
                end
                wvenv_pkg::OP_TICK: begin
                    ph  = 32'((phase >> 20) % DEPTH);
                    lvl = level_now();
                    v = longint'(wave[ph]) * longint'(lvl) / ONE_Q15;
                    if (drive != 0) v = soft_clip(v * longint'(drive) / 4096);
                    v = v * longint'(gain) / ONE_Q15;
                    y = int'(v);
                    if (guard > 0) begin
                        d = (longint'(last_out) - y) * longint'(guard) / GUARD_LEN;
                        y = int'(y + d);
                        guard--;
                    end else
                        last_out = y;
                    exp_sample.push_back(y[15:0]);
                    exp_level.push_back(lvl[14:0]);
                    // advance phase and envelope
                    phase = (phase + step) % (longint'(DEPTH) << 20);
                    if (!resting) begin
                        if (!main_done) begin
                            env_pos++;
                            if (longint'(env_pos) >= longint'(att_len) + hld_len + dec_len)
                                main_done = 1;
                        end
                    end else if (!rel_done) begin
                        rel_pos++;
                        if (rel_pos >= rel_len) rel_done = 1;
                    end
                end
                default: ;
            endcase
        endfunction

        function void check_result(logic signed [15:0] smp, logic [14:0] lvl);
            logic signed [15:0] es;
            logic [14:0] el;
            if (exp_sample.size() == 0) begin
                errors++;
                if (shown < 10) begin
                    shown++;
                    $display("ERROR: unexpected result sample=%0d level=%0d", smp, lvl);
                end
                return;
            end
            es = exp_sample.pop_front();
            el = exp_level.pop_front();
            if (smp !== es || lvl !== el) begin
                errors++;
                if (shown < 10) begin
                    shown++;
                    $display("ERROR: sample exp %0d got %0d, level exp %0d got %0d",
                             es, smp, el, lvl);
                end
            end
        endfunction
    endclass

    logic               clk;
    logic               rst_n;
    logic               in_valid, in_ready;
    logic [2:0]         opcode;
    logic [30:0]        note_increment;
    logic [11:0]        table_index;
    logic signed [15:0] table_value;
    logic               out_valid, out_ready;
    logic signed [15:0] sample;
    logic [14:0]        envelope_level;
    logic               cfg_we;
    logic [2:0]         cfg_index;
    logic [wvenv_pkg::CFG_DW-1:0] cfg_data;

    voice_scoreboard sb;
    bit  steady_flow;   // no idling on either side
    bit  long_hold;     // receiver holds off once
    int  cycles;

    wavetable_voice_with_envelope_top i_dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready),
        .opcode(opcode), .note_increment(note_increment),
        .table_index(table_index), .table_value(table_value),
        .out_valid(out_valid), .out_ready(out_ready),
        .sample(sample), .envelope_level(envelope_level),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    initial
    begin
        clk = 0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        cycles = 0;
        forever
        begin
            @(posedge clk);
            cycles++;
            if (cycles > LIMIT)
            begin
                $display("wavetable_voice_with_envelope_top test failed");
                $finish;
            end
        end
    end

    function int gap_len();
        if (steady_flow) return 0;
        if ($urandom_range(0, 15) == 0) return $urandom_range(10, 40);
        if ($urandom_range(0, 1) == 0) return 0;
        return $urandom_range(1, 3);
    endfunction

    // receiver
    initial
    begin
        out_ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (long_hold)
            begin
                out_ready <= 1'b0;
                repeat (400) @(posedge clk);
                long_hold = 0;
                out_ready <= 1'b1;
            end
            else if (steady_flow || $urandom_range(0, 3) != 0)
                out_ready <= 1'b1;
            else
            begin
                out_ready <= 1'b0;
                if ($urandom_range(0, 7) == 0) repeat ($urandom_range(5, 30)) @(posedge clk);
            end
        end
    end

    // result monitor, sampled mid-cycle ahead of the transfer edge
    always @(negedge clk)
        if (rst_n && out_valid && out_ready)
            sb.check_result(sample, envelope_level);

    task automatic send(logic [2:0] op, logic [30:0] inc, logic [11:0] idx,
                        logic [15:0] val, bit pause);
        int g;
        in_valid       <= 1'b1;
        opcode         <= op;
        note_increment <= inc;
        table_index    <= idx;
        table_value    <= val;
        do @(negedge clk); while (!in_ready);
        @(posedge clk);
        sb.note_input(op, inc, idx, val);
        g = pause ? gap_len() : 0;
        if (g > 0)
        begin
            in_valid <= 1'b0;
            repeat (g) @(posedge clk);
        end
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (sb.exp_sample.size() != 0) @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
    endtask

    task automatic write_regs(logic [19:0] d [8]);
        for (int i = 0; i < 8; i++)
        begin
            cfg_we    <= 1'b1;
            cfg_index <= i[2:0];
            cfg_data  <= d[i];
            @(posedge clk);
            sb.set_reg(wvenv_pkg::cfg_idx_t'(i), d[i]);
        end
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    // at most half a table entry per tick
    function logic [30:0] rand_step();
        case ($urandom_range(0, 3))
            0:       return 31'($urandom_range(0, 1 << 19));
            1:       return 31'($urandom_range(0, 1000));
            2:       return 31'(1 << 19);
            default: return 31'($urandom_range(1 << 16, 1 << 19));
        endcase
    endfunction

    task automatic random_run(int n);
        int k;
        logic [2:0] op;
        for (int i = 0; i < n; i++)
        begin
            k = $urandom_range(0, 99);
            if (k < 68)      op = wvenv_pkg::OP_TICK;
            else if (k < 77) op = wvenv_pkg::OP_NOTE_ON;
            else if (k < 84) op = wvenv_pkg::OP_REST;
            else if (k < 88) op = wvenv_pkg::OP_SILENT;
            else if (k < 94) op = wvenv_pkg::OP_TABLE_WR;
            else if (k < 97) op = wvenv_pkg::OP_RESTART;
            else             op = 3'($urandom_range(6, 7));
            send(op, op == wvenv_pkg::OP_NOTE_ON ? rand_step() : 31'($urandom),
                 12'($urandom), 16'($urandom), 1'b1);
        end
    endtask

    logic [19:0] regs [8];

    initial
    begin
        sb = new();
        sb.clear();
        rst_n          <= 1'b0;
        in_valid       <= 1'b0;
        opcode         <= wvenv_pkg::OP_TICK;
        note_increment <= '0;
        table_index    <= '0;
        table_value    <= '0;
        cfg_we         <= 1'b0;
        cfg_index      <= wvenv_pkg::CFG_ATTACK;
        cfg_data       <= '0;
        steady_flow = 1;
        long_hold   = 0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // load the low part of the table with raw random 16-bit values
        for (int i = 0; i < FILL_LEN; i++)
            send(wvenv_pkg::OP_TABLE_WR, 31'($urandom), i[11:0], 16'($urandom), 1'b0);

        // directed, reset register values; the largest step visits the table middle and end
        send(wvenv_pkg::OP_TABLE_WR, '0, 12'd4095, 16'h7fff, 1'b0);
        send(wvenv_pkg::OP_TABLE_WR, '0, 12'd2047, 16'h1234, 1'b0);
        send(wvenv_pkg::OP_TABLE_WR, '0, 12'd0, 16'h8000, 1'b0);
        send(wvenv_pkg::OP_TICK, '0, '0, '0, 1'b0);
        send(wvenv_pkg::OP_NOTE_ON, 31'h7fff_ffff, '0, '0, 1'b0);
        repeat (3) send(wvenv_pkg::OP_TICK, '0, '0, '0, 1'b0);
        send(wvenv_pkg::OP_RESTART, '0, '0, '0, 1'b0);
        send(wvenv_pkg::OP_NOTE_ON, 31'd1 << 20, '0, '0, 1'b0);
        repeat (3) send(wvenv_pkg::OP_TICK, '0, '0, '0, 1'b0);
        send(wvenv_pkg::OP_REST, '0, '0, '0, 1'b0);
        send(wvenv_pkg::OP_TICK, '0, '0, '0, 1'b0);
        send(wvenv_pkg::OP_SILENT, '0, '0, '0, 1'b0);
        send(wvenv_pkg::OP_TICK, '0, '0, '0, 1'b0);
        send(3'd6, '0, '0, '0, 1'b0);
        send(3'd7, '0, '0, '0, 1'b0);
        send(wvenv_pkg::OP_RESTART, '0, '0, '0, 1'b0);
        send(wvenv_pkg::OP_TICK, '0, '0, '0, 1'b0);
        send(wvenv_pkg::OP_NOTE_ON, '0, '0, '0, 1'b0);
        send(wvenv_pkg::OP_TICK, '0, '0, '0, 1'b0);
        drain();

        // short stages so every envelope phase is crossed; long receiver hold
        regs = '{20'd5, 20'd3, 20'd7, 20'd6, 20'd30000, 20'd9000, 20'h04000, 20'd8192};
        write_regs(regs);
        steady_flow = 0;
        long_hold = 1;
        random_run(70);
        drain();

        // extremes: shortest stages, zero hold, full drive and most negative gain
        regs = '{20'd1, 20'd0, 20'd1, 20'd1, 20'd32767, 20'd0, 20'h08000, 20'hffff};
        write_regs(regs);
        steady_flow = 1;
        random_run(40);
        steady_flow = 0;
        random_run(30);
        drain();

        // longest stages, zero peak, full sustain, largest gain, least drive
        regs = '{20'hfffff, 20'hfffff, 20'hfffff, 20'hfffff, 20'd0, 20'd32767,
                 20'h07fff, 20'd1};
        write_regs(regs);
        random_run(40);
        drain();

        // a few random settings with small stage lengths
        for (int p = 0; p < 3; p++)
        begin
            regs = '{20'($urandom_range(1, 12)), 20'($urandom_range(0, 8)),
                     20'($urandom_range(1, 12)), 20'($urandom_range(1, 12)),
                     20'($urandom_range(0, 32767)), 20'($urandom_range(0, 32767)),
                     20'($urandom_range(0, 65535)), 20'($urandom_range(0, 65535))};
            write_regs(regs);
            random_run(25);
            drain();
        end

        if (sb.errors == 0 && sb.exp_sample.size() == 0)
            $display("wavetable_voice_with_envelope_top test passed");
        else
            $display("wavetable_voice_with_envelope_top test failed");
        $finish;
    end

endmodule
